@@ design/sat_pkg.sv @@
// Shared types and constants for the source address admission table.
// Used by the interfaces, the table memory, the scan controller and the top level.
// No dependencies.
package sat_pkg;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int TICK_W     = 32;
    localparam int MAX_W      = 8;
    localparam int CNT_OUT_W  = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Table geometry
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Saturation point of the reported count
    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 7'd127;

    // Reset values of the configuration registers
    localparam logic [TICK_W-1:0] HOLD_TICKS_RESET      = 32'd30000;
    localparam logic [MAX_W-1:0]  MAX_PER_ADDRESS_RESET = 8'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_ADDRESS = 1'b1;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // One table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [TICK_W-1:0] expiry;
    } t_entry;

endpackage

@@ design/sat_req_if.sv @@
// Request channel of the admission table: command, address and current tick.
// Depends on sat_pkg.
interface sat_req_if import sat_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ADDR_W-1:0] ip_address;
    logic [TICK_W-1:0] now_ticks;

    modport source (output valid, command, ip_address, now_ticks, input ready);
    modport sink   (input valid, command, ip_address, now_ticks, output ready);
endinterface

@@ design/sat_rsp_if.sv @@
// Response channel of the admission table: admit flag and match count.
// Depends on sat_pkg.
interface sat_rsp_if import sat_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [CNT_OUT_W-1:0] match_count;

    modport source (output valid, accepted, match_count, input ready);
    modport sink   (input valid, accepted, match_count, output ready);
endinterface

@@ design/source_address_admission_table.sv @@
// Top level of the source address admission table: configuration registers,
// entry memory and scan controller.
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sat_table_mem, sat_ctrl.
//
//   channel   dir   handshake       payload
//   i_req     in    valid/ready     command, ip_address, now_ticks
//   o_rsp     out   valid/ready     accepted, match_count
//   i_cfg_*   in    write enable    register index, 32-bit data
//
// Each transaction makes one read per entry through the single memory read port,
// whose read data is registered, with acceptance before the scan and the final
// write-back with result post after it.
// After reset every table entry is swept with i_req.ready low.
// A waiting result does not stop the next transaction from being taken; it
// only holds the final cycle until the result register is free.
module source_address_admission_table import sat_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sat_req_if.sink               i_req,
    sat_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [TICK_W-1:0] r_hold_ticks;
    logic [MAX_W-1:0]  r_max_per_address;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    t_entry        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    t_entry        wr_data;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks      <= HOLD_TICKS_RESET;
            r_max_per_address <= MAX_PER_ADDRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_TICKS:      r_hold_ticks      <= TICK_W'(i_cfg_data);
                CFG_MAX_PER_ADDRESS: r_max_per_address <= i_cfg_data[MAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sat_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data)
    );

    sat_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (i_req),
        .o_rsp             (o_rsp),
        .i_hold_ticks      (r_hold_ticks),
        .i_max_per_address (r_max_per_address),
        .o_rd_en           (rd_en),
        .o_rd_idx          (rd_idx),
        .i_rd_data         (rd_data),
        .o_wr_en           (wr_en),
        .o_wr_idx          (wr_idx),
        .o_wr_data         (wr_data)
    );

endmodule

@@ design/sat_table_mem.sv @@
// Entry memory of the admission table: one write port, one registered read port.
// Depends on sat_pkg (t_entry).
module sat_table_mem import sat_pkg::*; #(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_idx,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/sat_ctrl.sv @@
// Scan controller: clears the table after reset, walks all entries for each
// transaction, frees expired or deleted entries and stores admitted addresses.
// Depends on sat_pkg, sat_req_if, sat_rsp_if; drives sat_table_mem ports.
module sat_ctrl import sat_pkg::*; #(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sat_req_if.sink           i_req,
    sat_rsp_if.source         o_rsp,
    input  logic [TICK_W-1:0] i_hold_ticks,
    input  logic [MAX_W-1:0]  i_max_per_address,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_idx,
    input  t_entry            i_rd_data,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_idx,
    output t_entry            o_wr_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MAX_W) ? CW : MAX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_chk_vld, n_chk_vld;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_have_free, n_have_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_out_vld, n_out_vld;
    logic          r_out_acc, n_out_acc;
    logic [CNT_OUT_W-1:0] r_out_cnt, n_out_cnt;
    logic              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [TICK_W-1:0] r_now, n_now;

    logic [CMPW-1:0]      cnt_ext;
    logic [CNT_OUT_W-1:0] cnt_sat;
    logic                 admit;
    logic                 expired;
    logic                 addr_hit;

    // Count as reported and the admission decision
    assign cnt_ext  = CMPW'(r_count);
    assign cnt_sat  = (cnt_ext > CMPW'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[CNT_OUT_W-1:0];
    assign admit    = (r_cmd == CMD_ADD) && r_have_free
                      && (cnt_ext < CMPW'(i_max_per_address));
    assign expired  = r_now > i_rd_data.expiry;
    assign addr_hit = i_rd_data.address == r_addr;

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.accepted    = r_out_acc;
    assign o_rsp.match_count = r_out_cnt;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_rd_idx     = r_rd_idx;
        n_issue_done = r_issue_done;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_count      = r_count;
        n_have_free  = r_have_free;
        n_free_idx   = r_free_idx;
        n_out_vld    = r_out_vld;
        n_out_acc    = r_out_acc;
        n_out_cnt    = r_out_cnt;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_now        = r_now;
        o_rd_en      = 1'b0;
        o_rd_idx     = r_rd_idx;
        o_wr_en      = 1'b0;
        o_wr_idx     = r_chk_idx;
        o_wr_data    = '0;

        // Drop the result once it is taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // Sweep the table, one entry per cycle
                o_wr_en  = 1'b1;
                o_wr_idx = r_clr_idx;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = IW'(r_clr_idx + 1'b1);
                end
            end
            ST_IDLE: begin
                // Take a new transaction and start the scan
                if (i_req.valid) begin
                    n_cmd        = i_req.command;
                    n_addr       = i_req.ip_address;
                    n_now        = i_req.now_ticks;
                    n_rd_idx     = '0;
                    n_issue_done = 1'b0;
                    n_chk_vld    = 1'b0;
                    n_count      = '0;
                    n_have_free  = 1'b0;
                    n_free_idx   = '0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next read
                n_chk_vld = 1'b0;
                if (!r_issue_done) begin
                    o_rd_en   = 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_rd_idx = IW'(r_rd_idx + 1'b1);
                    end
                end
                // Check the entry read last cycle and write back a cleared mark where it is freed
                if (r_chk_vld) begin
                    if (r_cmd == CMD_ADD) begin
                        if (i_rd_data.valid) begin
                            if (expired) begin
                                o_wr_en = 1'b1;
                                if (!r_have_free) begin
                                    n_have_free = 1'b1;
                                    n_free_idx  = r_chk_idx;
                                end
                            end else if (addr_hit) begin
                                n_count = CW'(r_count + 1'b1);
                            end
                        end else if (!r_have_free) begin
                            n_have_free = 1'b1;
                            n_free_idx  = r_chk_idx;
                        end
                    end else if (i_rd_data.valid && addr_hit) begin
                        o_wr_en = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                    end
                    if (r_chk_idx == LAST_IDX) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Store the admitted address and post the result when the slot is free
                if (!r_out_vld || o_rsp.ready) begin
                    o_wr_en   = admit;
                    o_wr_idx  = r_free_idx;
                    o_wr_data = '{valid: 1'b1, address: r_addr,
                                  expiry: TICK_W'(r_now + i_hold_ticks)};
                    n_out_vld = 1'b1;
                    n_out_acc = admit;
                    n_out_cnt = cnt_sat;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state   = ST_CLEAR;
                n_clr_idx = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_rd_idx     <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_count      <= '0;
            r_have_free  <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_rd_idx     <= n_rd_idx;
            r_issue_done <= n_issue_done;
            r_chk_vld    <= n_chk_vld;
            r_count      <= n_count;
            r_have_free  <= n_have_free;
            r_out_vld    <= n_out_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_out_acc  <= n_out_acc;
        r_out_cnt  <= n_out_cnt;
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_now      <= n_now;
    end

endmodule

@@ design/sat_checker.sv @@
// Port-level checks for the admission table, bound to the top level.
// Depends on sat_pkg and source_address_admission_table.
module sat_checker import sat_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic                  i_rsp_accepted,
    input logic [CNT_OUT_W-1:0]  i_rsp_match_count,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [MAX_W-1:0] r_max_per_address;

    // Track the limit as written on the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_address <= MAX_PER_ADDRESS_RESET;
        end else if (i_cfg_we && (i_cfg_idx == CFG_MAX_PER_ADDRESS)) begin
            r_max_per_address <= i_cfg_data[MAX_W-1:0];
        end
    end

    // One transaction at a time: ready drops after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in flight");

    // An admitted address was below the limit
    a_admit_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_accepted)
            |-> ({1'b0, i_rsp_match_count} < r_max_per_address))
        else $error("admitted at or above the per-address limit");

    // A new result appears only after the request side was closed
    a_rsp_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("result posted without a scan");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready)
            |=> (i_rsp_valid && $stable(i_rsp_accepted) && $stable(i_rsp_match_count)))
        else $error("stalled result changed");

endmodule

bind source_address_admission_table sat_checker u_sat_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_accepted    (o_rsp.accepted),
    .i_rsp_match_count (o_rsp.match_count),
    .i_cfg_we          (i_cfg_we),
    .i_cfg_idx         (i_cfg_idx),
    .i_cfg_data        (i_cfg_data)
);
